// ===== sv/tma_pkg.sv =====
package tma_pkg;

    // Block sizing
    localparam int WINDOW   = 7;
    localparam int CHANNELS = 3;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 2;
    localparam int FILT_W   = 20;
    localparam int LIMIT_W  = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd16400;

    // Window store geometry
    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int ADDR_W = $clog2(DEPTH);

    // Arithmetic widths
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW) + 1;
    localparam int CMP_W   = SUM_W + 1;
    localparam int Q_W     = SUM_W + 4;
    localparam int DIVISOR = WINDOW - 2;

    // Reciprocal of the divisor, scaled by 2^RS
    localparam int RS      = 32;
    localparam int RECIP_W = RS + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RS) / 64'(DIVISOR));
    localparam int PROD_W  = Q_W + RECIP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_TRIM,
        S_MAG,
        S_MUL,
        S_CORR,
        S_DONE
    } t_state;

endpackage

// ===== sv/trimmed_moving_average.sv =====
// Trimmed moving average over per-channel sample windows. Each input word carries one
// signed 16-bit sample and its channel; the sample replaces the oldest entry of that
// channel's WINDOW-deep ring in a simple dual-port window memory, after which the ring is
// read back one entry per cycle to form the sum, maximum and minimum. The trimmed sum
// (sum less max and min) is divided by WINDOW-2 via a reciprocal multiply and one
// correction step, giving the mean with 4 fraction bits, truncated toward zero. If the
// mean's magnitude exceeds rate_limit the channel's previous result is repeated with the
// held flag set. After acceptance an item runs through the sequential scan of the window
// memory, then the drain, trim, limit check, multiply, correction and output states; the
// output state waits while the output register still holds an unread result, and the
// block then returns to idle, where it takes the next word. Items are taken one at a
// time, and the next item is accepted while a finished result waits on the output.
// Channel values of CHANNELS or above are dropped without a result. rate_limit is
// written through i_cfg_we / i_cfg_wdata; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module trimmed_moving_average (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_we,
    input  logic [tma_pkg::LIMIT_W-1:0]   i_cfg_wdata,    // rate_limit
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] sample
    input  logic [1:0]                    s_axis_tuser,   // [1:0] channel
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // [19:0] filtered, [23:20] zero
    output logic [2:0]                    m_axis_tuser    // [1:0] out_channel, [2] held
);

    tma_pkg::t_state r_state, n_state;

    // Configuration register
    logic [tma_pkg::LIMIT_W-1:0] r_limit;

    // Window memory and per-entry valid bits
    logic signed [tma_pkg::SAMPLE_W-1:0] r_mem [tma_pkg::DEPTH];
    logic [tma_pkg::DEPTH-1:0]           r_vld;
    logic signed [tma_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                                r_rd_vld;
    logic                                r_rd_pend;

    // Per-channel ring pointers and last results
    logic [tma_pkg::PTR_W-1:0]           r_ptr  [tma_pkg::CHANNELS];
    logic signed [tma_pkg::FILT_W-1:0]   r_last [tma_pkg::CHANNELS];

    // Item context
    logic [tma_pkg::CH_W-1:0]            r_ch;
    logic [tma_pkg::PTR_W-1:0]           r_wslot;
    logic [tma_pkg::ADDR_W-1:0]          r_base;
    logic [tma_pkg::PTR_W-1:0]           r_idx;

    // Datapath registers
    logic signed [tma_pkg::SUM_W-1:0]    r_sum;
    logic signed [tma_pkg::SAMPLE_W-1:0] r_max;
    logic signed [tma_pkg::SAMPLE_W-1:0] r_min;
    logic signed [tma_pkg::SUM_W-1:0]    r_trim;
    logic [tma_pkg::Q_W-1:0]             r_mag16;
    logic                                r_neg;
    logic                                r_hold;
    logic [tma_pkg::PROD_W-1:0]          r_prod;
    logic [tma_pkg::Q_W-1:0]             r_q;

    // Output register
    logic                                r_m_valid;
    logic signed [tma_pkg::FILT_W-1:0]   r_m_filt;
    logic [tma_pkg::CH_W-1:0]            r_m_ch;
    logic                                r_m_held;

    // Combinational
    logic                                w_ch_ok;
    logic                                w_accept;
    logic                                w_scan;
    logic                                w_out_free;
    logic                                w_done;
    logic [tma_pkg::ADDR_W-1:0]          w_wr_addr;
    logic [tma_pkg::ADDR_W-1:0]          w_rd_addr;
    logic signed [tma_pkg::SAMPLE_W-1:0] w_sample;
    logic signed [tma_pkg::SAMPLE_W-1:0] w_rd_sample;
    logic [tma_pkg::SUM_W-1:0]           w_mag;
    logic [tma_pkg::Q_W-1:0]             w_q0;
    logic [tma_pkg::Q_W-1:0]             w_qd;
    logic [tma_pkg::Q_W-1:0]             w_rem;
    logic [tma_pkg::Q_W-1:0]             w_res;
    logic signed [tma_pkg::FILT_W-1:0]   w_filt;

    assign w_sample    = s_axis_tdata;
    assign w_ch_ok     = 32'(s_axis_tuser) < tma_pkg::CHANNELS;
    assign w_out_free  = !r_m_valid || m_axis_tready;
    assign w_wr_addr   = tma_pkg::ADDR_W'(32'(s_axis_tuser) * tma_pkg::WINDOW
                                          + 32'(r_ptr[s_axis_tuser]));
    assign w_rd_addr   = r_base + tma_pkg::ADDR_W'(r_idx);
    assign w_rd_sample = r_rd_vld ? r_rd_data : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tma_pkg::S_IDLE: begin
                if (s_axis_tvalid && w_ch_ok) n_state = tma_pkg::S_SCAN;
            end
            tma_pkg::S_SCAN: begin
                if (32'(r_idx) == tma_pkg::WINDOW - 1) n_state = tma_pkg::S_DRAIN;
            end
            tma_pkg::S_DRAIN: n_state = tma_pkg::S_TRIM;
            tma_pkg::S_TRIM:  n_state = tma_pkg::S_MAG;
            tma_pkg::S_MAG:   n_state = tma_pkg::S_MUL;
            tma_pkg::S_MUL:   n_state = tma_pkg::S_CORR;
            tma_pkg::S_CORR:  n_state = tma_pkg::S_DONE;
            tma_pkg::S_DONE: begin
                if (w_out_free) n_state = tma_pkg::S_IDLE;
            end
            default: n_state = tma_pkg::S_IDLE;
        endcase
    end

    // State decodes
    always_comb begin
        s_axis_tready = 1'b0;
        w_scan        = 1'b0;
        w_done        = 1'b0;
        case (r_state)
            tma_pkg::S_IDLE: s_axis_tready = 1'b1;
            tma_pkg::S_SCAN: w_scan        = 1'b1;
            tma_pkg::S_DONE: w_done        = w_out_free;
            default: ;
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready && w_ch_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tma_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_limit <= tma_pkg::LIMIT_RST;
        else if (i_cfg_we) r_limit <= i_cfg_wdata;
    end

    // Window memory: write new sample on accept, registered read during scan
    always_ff @(posedge i_clk) begin
        if (w_accept) r_mem[w_wr_addr] <= w_sample;
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Valid bits, ring pointers and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_pend <= 1'b0;
            for (int c = 0; c < tma_pkg::CHANNELS; c++) r_ptr[c] <= '0;
        end else begin
            r_rd_vld  <= r_vld[w_rd_addr];
            r_rd_pend <= w_scan && (r_idx != r_wslot);
            if (w_accept) begin
                r_vld[w_wr_addr] <= 1'b1;
                if (32'(r_ptr[s_axis_tuser]) == tma_pkg::WINDOW - 1)
                    r_ptr[s_axis_tuser] <= '0;
                else
                    r_ptr[s_axis_tuser] <= r_ptr[s_axis_tuser] + 1'b1;
            end
        end
    end

    // Item context and scan index
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch    <= s_axis_tuser;
            r_wslot <= r_ptr[s_axis_tuser];
            r_base  <= tma_pkg::ADDR_W'(32'(s_axis_tuser) * tma_pkg::WINDOW);
            r_idx   <= '0;
        end else if (w_scan) begin
            r_idx   <= r_idx + 1'b1;
        end
    end

    // Sum and extremes: seeded with the new sample, then the other window entries
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sum <= tma_pkg::SUM_W'(w_sample);
            r_max <= w_sample;
            r_min <= w_sample;
        end else if (r_rd_pend) begin
            r_sum <= r_sum + tma_pkg::SUM_W'(w_rd_sample);
            if (w_rd_sample > r_max) r_max <= w_rd_sample;
            if (w_rd_sample < r_min) r_min <= w_rd_sample;
        end
    end

    // Trim, magnitude, limit check and division by WINDOW-2
    assign w_mag = r_trim[tma_pkg::SUM_W-1] ? tma_pkg::SUM_W'(-r_trim)
                                            : tma_pkg::SUM_W'(r_trim);
    assign w_q0  = r_prod[tma_pkg::RS +: tma_pkg::Q_W];
    assign w_qd  = w_q0 * tma_pkg::Q_W'(tma_pkg::DIVISOR);
    assign w_rem = r_mag16 - w_qd;
    assign w_res = r_neg ? -r_q : r_q;

    always_ff @(posedge i_clk) begin
        if (r_state == tma_pkg::S_TRIM)
            r_trim <= r_sum - tma_pkg::SUM_W'(r_max) - tma_pkg::SUM_W'(r_min);
        if (r_state == tma_pkg::S_MAG) begin
            r_mag16 <= {w_mag, 4'b0000};
            r_neg   <= r_trim[tma_pkg::SUM_W-1];
            r_hold  <= tma_pkg::CMP_W'(w_mag) >
                       tma_pkg::CMP_W'(r_limit) * tma_pkg::CMP_W'(tma_pkg::DIVISOR);
        end
        if (r_state == tma_pkg::S_MUL)
            r_prod <= tma_pkg::PROD_W'(r_mag16) * tma_pkg::PROD_W'(tma_pkg::RECIP);
        // estimate is at most one short
        if (r_state == tma_pkg::S_CORR)
            r_q <= (w_rem >= tma_pkg::Q_W'(tma_pkg::DIVISOR)) ? w_q0 + 1'b1 : w_q0;
    end

    assign w_filt = r_hold ? r_last[r_ch] : w_res[tma_pkg::FILT_W-1:0];

    // Last result per channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < tma_pkg::CHANNELS; c++) r_last[c] <= '0;
        end else if (w_done && !r_hold) begin
            r_last[r_ch] <= w_filt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)           r_m_valid <= 1'b0;
        else if (w_done)        r_m_valid <= 1'b1;
        else if (m_axis_tready) r_m_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_m_filt <= w_filt;
            r_m_ch   <= r_ch;
            r_m_held <= r_hold;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_m_filt};
    assign m_axis_tuser  = {r_m_held, r_m_ch};

`ifndef SYNTHESIS
    // Ring pointer of the channel just taken stays inside the window
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> 32'(r_ptr[r_ch]) < tma_pkg::WINDOW)
        else $error("ring pointer out of range");

    // An accepted word starts the window scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == tma_pkg::S_SCAN)
        else $error("accepted word did not start a scan");

    // The output register is loaded only at the end of an item
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == tma_pkg::S_DONE)
        else $error("result shown without a finished item");

    // A held result repeats the channel's stored value
    a_held_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_m_held) |-> r_m_filt == r_last[r_m_ch])
        else $error("held result differs from stored value");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 600000;
    // settle time after the last result, covers a dropped word still in flight
    localparam int SETTLE = 30;

    // One expected result word
    typedef struct {
        logic [tma_pkg::CH_W-1:0]          ch;
        logic signed [tma_pkg::FILT_W-1:0] filtered;
        logic                              held;
    } t_mean;

    // Per-channel window tracking and expected trimmed means
    class trimmed_mean_tracker;
        logic signed [tma_pkg::SAMPLE_W-1:0] window [tma_pkg::CHANNELS][tma_pkg::WINDOW];
        logic signed [tma_pkg::FILT_W-1:0]   last_mean [tma_pkg::CHANNELS];
        logic [tma_pkg::LIMIT_W-1:0]         limit;
        t_mean                               expected_means [$];
        int                                  errors;

        function new();
            for (int c = 0; c < tma_pkg::CHANNELS; c++) begin
                last_mean[c] = '0;
                for (int i = 0; i < tma_pkg::WINDOW; i++)
                    window[c][i] = '0;
            end
            limit  = tma_pkg::LIMIT_RST;
            errors = 0;
        endfunction

        function void set_limit(logic [tma_pkg::LIMIT_W-1:0] value);
            limit = value;
        endfunction

        // Shift the sample in and work out the result it causes
        function void take_sample(logic [tma_pkg::CH_W-1:0] ch,
                                  logic signed [tma_pkg::SAMPLE_W-1:0] smp);
            longint total, top, bottom, trimmed, mag, bound, quot;
            t_mean  want;
            if (ch >= tma_pkg::CHANNELS)
                return;
            for (int i = tma_pkg::WINDOW - 1; i > 0; i--)
                window[ch][i] = window[ch][i-1];
            window[ch][0] = smp;
            total  = 0;
            top    = window[ch][0];
            bottom = window[ch][0];
            for (int i = 0; i < tma_pkg::WINDOW; i++) begin
                total += window[ch][i];
                if (window[ch][i] > top)
                    top = window[ch][i];
                if (window[ch][i] < bottom)
                    bottom = window[ch][i];
            end
            trimmed = total - top - bottom;
            mag     = (trimmed < 0) ? -trimmed : trimmed;
            bound   = longint'(limit) * (tma_pkg::WINDOW - 2);
            want.held = (mag > bound);
            if (!want.held) begin
                // signed division truncates toward zero
                quot = (trimmed * 16) / (tma_pkg::WINDOW - 2);
                last_mean[ch] = tma_pkg::FILT_W'(quot);
            end
            want.ch       = ch;
            want.filtered = last_mean[ch];
            expected_means.push_back(want);
        endfunction

        function void check_mean(logic [23:0] data, logic [2:0] user);
            t_mean want;
            if (expected_means.size() == 0) begin
                $error("unexpected word: out_channel %0d filtered %0d", user[1:0],
                       $signed(data[19:0]));
                errors++;
                return;
            end
            want = expected_means.pop_front();
            if (user[1:0] !== want.ch) begin
                $error("out_channel: expected %0d, got %0d", want.ch, user[1:0]);
                errors++;
            end
            if (data[19:0] !== want.filtered) begin
                $error("filtered: expected %0d, got %0d", want.filtered, $signed(data[19:0]));
                errors++;
            end
            if (user[2] !== want.held) begin
                $error("held: expected %0d, got %0d", want.held, user[2]);
                errors++;
            end
            if (data[23:20] !== 4'd0) begin
                $error("tdata padding: expected 0, got %0h", data[23:20]);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_means.size();
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [tma_pkg::LIMIT_W-1:0]  i_cfg_wdata;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [15:0]                  s_axis_tdata;    // [15:0] sample
    logic [1:0]                   s_axis_tuser;    // [1:0] channel
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [23:0]                  m_axis_tdata;    // [19:0] filtered, [23:20] zero
    logic [2:0]                   m_axis_tuser;    // [1:0] out_channel, [2] held

    trimmed_mean_tracker board = new();
    int  cycles = 0;
    int  cur_limit = tma_pkg::LIMIT_RST;
    bit  calm = 1'b0;
    bit  stall_req = 1'b0;

    trimmed_moving_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check accepted words, random back-pressure, one long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                board.check_mean(m_axis_tdata, m_axis_tuser);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_req) begin
                stall_req = 1'b0;
                stall_left = 300;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    // Offer one word and hold it until taken; tvalid stays high afterwards
    task automatic send_word(input logic [1:0] ch, input logic [15:0] smp);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_sample(ch, smp);
    endtask

    task automatic pause(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(99) < 16)
            pause($urandom_range(1, 15));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Only called with the block idle
    task automatic write_limit(input logic [tma_pkg::LIMIT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.set_limit(value);
        cur_limit = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample(input int style);
        int level;
        case (style)
            0: return 16'($urandom);
            // hovering around the limit, either sign
            1: begin
                level = (cur_limit > 32767) ? 32767 : cur_limit;
                if ($urandom_range(1))
                    level = -level;
                level += int'($urandom_range(4)) - 2;
                if (level > 32767)
                    level = 32767;
                if (level < -32768)
                    level = -32768;
                return 16'(level);
            end
            2: begin
                case ($urandom_range(3))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            // narrow spread, plenty of ties
            default: return 16'(int'($urandom_range(6)) - 3);
        endcase
    endfunction

    // Bursts on one channel with a shared flavour, odd out-of-range words between
    task automatic random_phase(input int n_items);
        int counted;
        int burst;
        int style;
        logic [1:0] ch;
        counted = 0;
        while (counted < n_items) begin
            if ($urandom_range(19) == 0) begin
                send_word(2'd3, 16'($urandom));
                sender_gap();
            end
            ch    = 2'($urandom_range(tma_pkg::CHANNELS - 1));
            burst = $urandom_range(1, 10);
            style = $urandom_range(3);
            repeat (burst) begin
                send_word(ch, pick_sample(style));
                counted++;
                sender_gap();
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset limit, positive extreme fills channel 0 until it holds
        repeat (5) send_word(2'd0, 16'h7fff);
        // negative extreme, truncation toward zero
        repeat (3) send_word(2'd1, 16'h8000);
        // out-of-range channel is dropped
        send_word(2'd3, 16'h5a5a);
        send_word(2'd2, 16'hffff);
        send_word(2'd2, 16'h0001);
        wait_drained();

        // Mean exactly on the limit is accepted, just over it holds
        write_limit(16'd100);
        repeat (7) send_word(2'd2, 16'd100);
        repeat (2) send_word(2'd2, 16'd101);
        wait_drained();

        // Random phases across limit settings
        write_limit(16'd0);
        random_phase(200);
        wait_drained();

        write_limit(16'hffff);
        random_phase(100);
        wait_drained();
        random_phase(100);
        wait_drained();

        write_limit(16'd32768);
        calm = 1'b1;
        random_phase(200);
        calm = 1'b0;
        wait_drained();

        write_limit(16'd1);
        random_phase(200);
        wait_drained();

        write_limit(16'($urandom_range(32768)));
        random_phase(50);
        stall_req = 1'b1;
        random_phase(150);
        wait_drained();

        write_limit(16'($urandom));
        random_phase(200);
        wait_drained();

        write_limit(16'($urandom_range(100, 2000)));
        random_phase(200);
        wait_drained();

        write_limit(tma_pkg::LIMIT_RST);
        random_phase(160);
        wait_drained();

        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== trimmed_moving_average.f =====
sv/tma_pkg.sv
sv/trimmed_moving_average.sv
tb/testbench.sv
